>>> hdl/wfd_pkg.sv
// Package for the wait-for deadlock detector: transaction structs, entry
// layout, opcode codes and default sizes. No dependencies.
package wfd_pkg;

    // Default number of agents in the wait-for table.
    localparam int AGENTS_DEFAULT = 64;
    // Width of an agent index on the ports.
    localparam int AGENT_W = 6;
    // Largest table the agent index can address.
    localparam int AGENT_SPAN = 1 << AGENT_W;

    // Opcodes.
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic               opcode;
        logic [AGENT_W-1:0] agent;
        logic [AGENT_W-1:0] waits_on;
        logic               by_constraint;
    } t_in_item;

    // Result transaction.
    typedef struct packed {
        logic deadlock;
        logic cycle_found;
        logic constraint_in_cycle;
    } t_out_item;

    // One stored wait relation.
    typedef struct packed {
        logic [AGENT_W-1:0] waits_on;
        logic               by_constraint;
    } t_entry;

    // Request from the walk sequencer to the table.
    typedef struct packed {
        logic               wr_en;
        logic [AGENT_W-1:0] wr_agent;
        t_entry             wr_entry;
        logic [AGENT_W-1:0] rd_agent;
    } t_tbl_req;

endpackage

>>> hdl/wfd_table.sv
// Wait-for table: one entry per agent in a memory with a registered read,
// plus per-entry valid flops cleared by reset. Depends on wfd_pkg.
module wfd_table #(
    parameter int AGENTS = wfd_pkg::AGENTS_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wfd_pkg::t_tbl_req i_req,
    output logic              o_rd_hit,
    output wfd_pkg::t_entry   o_rd_entry
);
    import wfd_pkg::*;

    // Only indexes the agent field can reach need storage.
    localparam int DEPTH = (AGENTS < AGENT_SPAN) ? AGENTS : AGENT_SPAN;
    localparam int IW    = $clog2(DEPTH);
    localparam logic [AGENT_W:0] DEPTH_V = (AGENT_W+1)'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic             wr_in_range;
    logic             rd_in_range;
    logic [IW-1:0]    wr_idx;
    logic [IW-1:0]    rd_idx;

    // Index range checks; out-of-range agents have no entry.
    assign wr_in_range = {1'b0, i_req.wr_agent} < DEPTH_V;
    assign rd_in_range = {1'b0, i_req.rd_agent} < DEPTH_V;
    assign wr_idx      = i_req.wr_agent[IW-1:0];
    assign rd_idx      = i_req.rd_agent[IW-1:0];

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_in_range) begin
            r_mem[wr_idx] <= i_req.wr_entry;
        end
        o_rd_entry <= r_mem[rd_idx];
    end

    // Valid flops, cleared at reset; the hit flag is registered with the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            o_rd_hit <= 1'b0;
        end else begin
            if (i_req.wr_en && wr_in_range) begin
                r_valid[wr_idx] <= 1'b1;
            end
            o_rd_hit <= rd_in_range && r_valid[rd_idx];
        end
    end

endmodule

>>> hdl/wfd_walker.sv
// Sequencer of the wait-for deadlock detector: accepts transactions, issues
// table writes and follows waits-on links one per cycle. Depends on wfd_pkg.
module wfd_walker #(
    parameter int AGENTS = wfd_pkg::AGENTS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wfd_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output wfd_pkg::t_out_item o_data,
    input  logic               i_remove_en,
    output wfd_pkg::t_tbl_req  o_tbl_req,
    input  logic               i_rd_hit,
    input  wfd_pkg::t_entry    i_rd_entry
);
    import wfd_pkg::*;

    localparam int SW = $clog2(AGENTS);
    localparam logic [SW-1:0] LAST_STEP = SW'(AGENTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0]         r_state;
    logic [AGENT_W-1:0] r_start;
    logic [SW-1:0]      r_step;
    logic               r_con;
    t_out_item          r_res;
    logic               con_now;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_res;
    assign con_now = r_con | i_rd_entry.by_constraint;

    // Table requests: writes for add transactions, reads of the next link.
    always_comb begin
        o_tbl_req.wr_en    = (r_state == S_IDLE) && i_valid && (i_data.opcode == OP_ADD);
        o_tbl_req.wr_agent = i_data.agent;
        o_tbl_req.wr_entry.waits_on      = i_data.waits_on;
        o_tbl_req.wr_entry.by_constraint = i_data.by_constraint;
        o_tbl_req.rd_agent = (r_state == S_IDLE) ? i_data.agent : i_rd_entry.waits_on;
    end

    // Walk control and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= '0;
            r_step  <= '0;
            r_con   <= 1'b0;
            r_res   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (i_data.opcode == OP_ADD) begin
                            r_res   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_start <= i_data.agent;
                            r_step  <= '0;
                            r_con   <= 1'b0;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (!i_rd_hit) begin
                        // Reached an agent with no entry.
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else if (i_rd_entry.waits_on == r_start) begin
                        // Back at the start: a cycle through the queried agent.
                        r_res.deadlock            <= !(i_remove_en && con_now);
                        r_res.cycle_found         <= 1'b1;
                        r_res.constraint_in_cycle <= con_now;
                        r_state                   <= S_OUT;
                    end else if (r_step == LAST_STEP) begin
                        // Step budget used up; any cycle avoids the start.
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 1'b1;
                        r_con  <= con_now;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hdl/wait_for_deadlock_detector.sv
// Top level of the wait-for deadlock detector: configuration register and
// the walk sequencer and table. Depends on wfd_pkg, wfd_table, wfd_walker.
//
// Usage: the input channel (i_valid/o_ready/i_data) takes one transaction
// at a time. An add writes or overwrites one agent's wait entry; a query
// follows the waits-on links from the given agent through the table and
// reports whether the walk returns to that agent. Every transaction gives
// one result on the output channel (o_valid/i_ready/o_data).
// Timing: an add presents its result in the cycle after acceptance. A query
// reads one table entry per walk step, at most AGENTS entries, and presents
// its result when the walk ends; the table memory delivers one entry per
// cycle, which sets the walk rate. The next transaction can be accepted in
// the cycle after the result is taken.
// o_ready stays low from acceptance until the result is taken.
// i_cfg_we writes the constraint-removal enable at once, without handshake.
// Reset clears all table entries, the enable and any transaction in flight.
// When the receiver stalls, the result is held on o_data and no new
// transaction is accepted until it is taken.
module wait_for_deadlock_detector #(
    parameter int AGENTS = wfd_pkg::AGENTS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wfd_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output wfd_pkg::t_out_item o_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata
);
    import wfd_pkg::*;

    logic     r_remove_en;
    t_tbl_req tbl_req;
    logic     rd_hit;
    t_entry   rd_entry;

    // Constraint-removal enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remove_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_remove_en <= i_cfg_wdata;
        end
    end

    wfd_walker #(
        .AGENTS (AGENTS)
    ) u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_remove_en (r_remove_en),
        .o_tbl_req   (tbl_req),
        .i_rd_hit    (rd_hit),
        .i_rd_entry  (rd_entry)
    );

    wfd_table #(
        .AGENTS (AGENTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (tbl_req),
        .o_rd_hit   (rd_hit),
        .o_rd_entry (rd_entry)
    );

endmodule

>>> tb/wait_for_deadlock_detector_tb.sv
// Self-checking testbench for the wait-for deadlock detector: directed and random
// adds and queries, checked against a wait-for table walk predicted in the bench.
// Depends on wfd_pkg and the wait_for_deadlock_detector RTL.
module wait_for_deadlock_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfd_pkg::*;

    localparam int N_AGENTS     = AGENTS_DEFAULT;
    localparam int CLK_HALF     = 2;
    localparam int IDLE_PCT     = 28;
    localparam int RESET_CYCLES = 6;

    // Scoreboard: holds a copy of the wait-for table and the expected results
    // of accepted transactions, oldest first.
    class deadlock_scoreboard;
        bit                 link_valid [N_AGENTS];
        logic [AGENT_W-1:0] link_to    [N_AGENTS];
        bit                 link_con   [N_AGENTS];
        bit                 remove_en;
        t_out_item          verdict_q  [$];
        int                 errors;
        int                 n_adds;
        int                 n_queries;
        int                 n_cycles;
        int                 n_deadlocks;
        int                 n_checked;

        function new();
            for (int i = 0; i < N_AGENTS; i++) begin
                link_valid[i] = 1'b0;
                link_to[i]    = '0;
                link_con[i]   = 1'b0;
            end
            remove_en   = 1'b0;
            errors      = 0;
            n_adds      = 0;
            n_queries   = 0;
            n_cycles    = 0;
            n_deadlocks = 0;
            n_checked   = 0;
        endfunction

        // Follow the waits-on links from the start agent for at most one
        // step per table entry, and judge any cycle back to the start.
        function t_out_item walk_from(logic [AGENT_W-1:0] start);
            t_out_item verdict;
            int        cur;
            bit        done;
            bit        con_seen;
            verdict  = '0;
            cur      = start;
            done     = 1'b0;
            con_seen = 1'b0;
            for (int s = 0; s < N_AGENTS && !done; s++) begin
                if (cur >= N_AGENTS || !link_valid[cur]) begin
                    done = 1'b1;
                end else begin
                    if (link_con[cur]) con_seen = 1'b1;
                    cur = link_to[cur];
                    if (cur == start) begin
                        verdict.cycle_found = 1'b1;
                        done = 1'b1;
                    end
                end
            end
            if (verdict.cycle_found) begin
                verdict.constraint_in_cycle = con_seen;
                verdict.deadlock            = !(remove_en && con_seen);
            end
            return verdict;
        endfunction

        // An accepted transaction updates the table or walks it.
        function void note_input(t_in_item item);
            t_out_item verdict;
            verdict = '0;
            if (item.opcode == OP_ADD) begin
                if (item.agent < N_AGENTS) begin
                    link_valid[item.agent] = 1'b1;
                    link_to[item.agent]    = item.waits_on;
                    link_con[item.agent]   = item.by_constraint;
                end
                n_adds++;
            end else begin
                verdict = walk_from(item.agent);
                n_queries++;
                if (verdict.cycle_found) n_cycles++;
                if (verdict.deadlock) n_deadlocks++;
            end
            verdict_q = {verdict_q, verdict};
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("result %b with no transaction outstanding", got));
            end else begin
                want = verdict_q.pop_front();
                n_checked++;
                if (got.deadlock !== want.deadlock)
                    report_mismatch($sformatf("deadlock %b, expected %b",
                                              got.deadlock, want.deadlock));
                if (got.cycle_found !== want.cycle_found)
                    report_mismatch($sformatf("cycle_found %b, expected %b",
                                              got.cycle_found, want.cycle_found));
                if (got.constraint_in_cycle !== want.constraint_in_cycle)
                    report_mismatch($sformatf("constraint_in_cycle %b, expected %b",
                                              got.constraint_in_cycle,
                                              want.constraint_in_cycle));
            end
        endtask

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_valid     = 1'b0;
    logic      o_ready;
    t_in_item  i_data      = '0;
    logic      o_valid;
    logic      i_ready     = 1'b0;
    t_out_item o_data;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    deadlock_scoreboard sb;
    bit                 no_idle      = 1'b0;
    int                 items_sent   = 0;
    int                 n_cfg_writes = 0;

    wait_for_deadlock_detector #(
        .AGENTS(N_AGENTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Clock, 4 ns period.
    always begin
        i_clk = 1'b0;
        #(CLK_HALF);
        i_clk = 1'b1;
        #(CLK_HALF);
    end

    // Monitor both channels at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_data);
            if (o_valid && i_ready) sb.check_result(o_data);
        end
    end

    // The result side stalls at random unless idling is switched off.
    always @(negedge i_clk) begin
        i_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Offer one transaction and hold it until it is accepted. Returns at the
    // falling edge after acceptance with valid still high.
    task automatic send_item(t_in_item item);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_add(logic [AGENT_W-1:0] agent, logic [AGENT_W-1:0] target,
                            logic con);
        t_in_item item;
        item.opcode        = OP_ADD;
        item.agent         = agent;
        item.waits_on      = target;
        item.by_constraint = con;
        send_item(item);
    endtask

    // The unused fields of a query carry random bits.
    task automatic send_query(logic [AGENT_W-1:0] agent);
        t_in_item item;
        item.opcode        = OP_QUERY;
        item.agent         = agent;
        item.waits_on      = AGENT_W'($urandom);
        item.by_constraint = 1'($urandom);
        send_item(item);
    endtask

    // Drop valid and wait until every result has come back, then let the
    // longest walk time pass.
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (N_AGENTS + 8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Write the constraint-removal enable while the block is idle.
    task automatic write_remove_enable(bit value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.remove_en = value;
        n_cfg_writes++;
    endtask

    // Random traffic: mostly chains, cycles and lassos over distinct agents
    // with random constraint bits, each followed by queries of its members;
    // the rest is loose adds and queries.
    task automatic run_random_phase(int n_items);
        int target;
        int order [N_AGENTS];
        int len;
        int kind;
        int j;
        int tmp;
        int nxt;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 70) begin
                for (int i = 0; i < N_AGENTS; i++) order[i] = i;
                for (int i = N_AGENTS - 1; i > 0; i--) begin
                    j        = $urandom_range(0, i);
                    tmp      = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                // Mostly short structures, now and then up to the whole table.
                len  = ($urandom_range(0, 15) == 0) ? $urandom_range(9, N_AGENTS)
                                                    : $urandom_range(1, 8);
                kind = $urandom_range(0, 2);
                for (int i = 0; i < len; i++) begin
                    if (i < len - 1) begin
                        nxt = order[i + 1];
                    end else begin
                        case (kind)
                            0: nxt = order[0];
                            1: nxt = order[$urandom_range(0, len - 1)];
                            default: nxt = $urandom_range(0, N_AGENTS - 1);
                        endcase
                    end
                    send_add(AGENT_W'(order[i]), AGENT_W'(nxt),
                             $urandom_range(0, 99) < 20);
                end
                // Occasionally break the structure before querying it.
                if ($urandom_range(0, 9) == 0)
                    send_add(AGENT_W'(order[$urandom_range(0, len - 1)]),
                             AGENT_W'($urandom_range(0, N_AGENTS - 1)),
                             1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 3))
                    send_query(AGENT_W'(order[$urandom_range(0, len - 1)]));
            end else if ($urandom_range(0, 1)) begin
                send_add(AGENT_W'($urandom), AGENT_W'($urandom), 1'($urandom));
            end else begin
                send_query(AGENT_W'($urandom));
            end
        end
    endtask

    // Main sequence.
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with removal off: empty table, self wait, a two-agent
        // cycle with a constraint, a cycle not through the start, a chain to
        // an agent with no entry, and an overwrite that closes a cycle.
        write_remove_enable(1'b0);
        send_query(6'd0);
        send_query(6'd63);
        send_add(6'd63, 6'd63, 1'b0);
        send_query(6'd63);
        send_add(6'd0, 6'd1, 1'b1);
        send_add(6'd1, 6'd0, 1'b0);
        send_query(6'd0);
        send_add(6'd2, 6'd3, 1'b0);
        send_add(6'd3, 6'd4, 1'b0);
        send_add(6'd4, 6'd3, 1'b1);
        send_query(6'd2);
        send_query(6'd3);
        send_add(6'd5, 6'd6, 1'b0);
        send_query(6'd5);
        send_add(6'd62, 6'd63, 1'b1);
        send_query(6'd62);
        send_add(6'd63, 6'd62, 1'b1);
        send_query(6'd62);
        drain();

        // Removal on: constraint cycles resolve, a plain self wait does not.
        write_remove_enable(1'b1);
        send_query(6'd0);
        send_query(6'd3);
        send_query(6'd62);
        send_add(6'd10, 6'd10, 1'b0);
        send_query(6'd10);
        send_query(6'd2);
        drain();

        // Random phases under both settings, one of them without idling.
        run_random_phase(500);
        drain();
        write_remove_enable(1'b0);
        no_idle = 1'b1;
        run_random_phase(400);
        drain();
        no_idle = 1'b0;
        write_remove_enable(1'b1);
        run_random_phase(500);
        drain();
        write_remove_enable(1'b0);
        run_random_phase(500);
        drain();

        $display("Ran %0d transactions: %0d adds, %0d queries, %0d results checked.",
                 items_sent, sb.n_adds, sb.n_queries, sb.n_checked);
        $display("Queries found %0d cycles and %0d deadlocks over %0d enable writes.",
                 sb.n_cycles, sb.n_deadlocks, n_cfg_writes);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Run time limit, several times the slowest expected run.
    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding.", sb.pending());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
